FILE: sv/srm_pkg.sv
package srm_pkg;

    // Default sample width of both channels
    localparam int SAMPLE_BITS_DEF = 24;

    // Phase accumulator, step and carrier formats
    localparam int PHASE_BITS   = 17;
    localparam int STEP_BITS    = 16;
    localparam int CARRIER_BITS = 16;
    localparam int FRAC_BITS    = 15;

    // Phase of pi and 2 pi in units of pi/32768, at the width of the phase sum
    localparam logic signed [PHASE_BITS:0] PHASE_PI     = 18'sd32768;
    localparam logic signed [PHASE_BITS:0] PHASE_TWO_PI = 18'sd65536;

    // Largest positive carrier magnitude in Q1.15
    localparam logic [CARRIER_BITS-1:0] CARRIER_MAX = 16'h7FFF;

    // Pipeline control handed from the top level to each lane
    typedef struct packed {
        logic adv;    // whole pipeline advances this cycle
        logic byp;    // item in the multiply stage passes unchanged
    } lane_ctrl_t;

endpackage

FILE: sv/srm_in_if.sv
interface srm_in_if
    import srm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          block_last;

    modport source (output valid, output left_sample, output right_sample,
                    output block_last, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input block_last, output ready);

endinterface

FILE: sv/srm_out_if.sv
interface srm_out_if
    import srm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          block_last_out;

    modport source (output valid, output left_out, output right_out,
                    output block_last_out, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input block_last_out, output ready);

endinterface

FILE: sv/srm_cfg_if.sv
interface srm_cfg_if
    import srm_pkg::*;
();

    logic                 valid;
    logic                 ready;
    logic [STEP_BITS-1:0] phase_step;

    modport source (output valid, output phase_step, input ready);
    modport sink   (input valid, input phase_step, output ready);

endinterface

FILE: sv/srm_carrier.sv
module srm_carrier
    import srm_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr,
    input  logic [STEP_BITS-1:0]           cfg_step,
    input  logic                           adv,
    input  logic                           accept,
    output logic                           step_zero,
    output logic signed [CARRIER_BITS-1:0] carrier
);

    logic [STEP_BITS-1:0]          phase_step_reg;
    logic signed [PHASE_BITS-1:0]  phase_reg;
    logic signed [PHASE_BITS-1:0]  phase_next;
    logic signed [PHASE_BITS:0]    phase_sum;
    logic signed [PHASE_BITS:0]    phase_wrap;
    logic [PHASE_BITS-1:0]         phase_abs;
    logic [CARRIER_BITS-1:0]       mag;
    logic [CARRIER_BITS-1:0]       rest;
    logic [2*CARRIER_BITS-1:0]     par_prod;
    logic [2*FRAC_BITS-2:0]        par_reg;
    logic                          neg_reg;
    logic [CARRIER_BITS-1:0]       mag_q;
    logic [CARRIER_BITS-1:0]       mag_clamp;

    assign step_zero = (phase_step_reg == '0);

    // Step register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
        end
        else if (cfg_wr)
        begin
            phase_step_reg <= cfg_step;
        end
    end

    // Phase advance with a single wrap by 2 pi
    always_comb
    begin
        phase_sum  = {phase_reg[PHASE_BITS-1], phase_reg}
                   + {2'b00, phase_step_reg};
        phase_wrap = (phase_sum > PHASE_PI) ? phase_sum - PHASE_TWO_PI : phase_sum;
        phase_next = phase_wrap[PHASE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (accept && !step_zero)
        begin
            phase_reg <= phase_next;
        end
    end

    // Parabola |p| * (pi - |p|), one multiply into a register
    always_comb
    begin
        phase_abs = phase_reg[PHASE_BITS-1] ? PHASE_BITS'(-phase_reg)
                                            : PHASE_BITS'(phase_reg);
        mag      = phase_abs[CARRIER_BITS-1:0];
        rest     = CARRIER_BITS'(PHASE_BITS'(PHASE_PI) - phase_abs);
        par_prod = mag * rest;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            par_reg <= par_prod[2*FRAC_BITS-2:0];
            neg_reg <= phase_reg[PHASE_BITS-1];
        end
    end

    // Scale by 4/32768, clamp and restore the sign
    always_comb
    begin
        mag_q     = par_reg[2*FRAC_BITS-2:FRAC_BITS-2];
        mag_clamp = mag_q[CARRIER_BITS-1] ? CARRIER_MAX : mag_q;
        carrier   = neg_reg ? -$signed(mag_clamp) : $signed(mag_clamp);
    end

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg <= 17'sd32768) && (phase_reg >= -17'sd32767))
        else $error("carrier phase left its range");

    a_bypass_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && step_zero && !cfg_wr) |=> $stable(phase_reg))
        else $error("phase moved on a bypassed item");

    a_carrier_bound: assert property (@(posedge clk) disable iff (!rst_n)
        carrier != {1'b1, {(CARRIER_BITS-1){1'b0}}})
        else $error("carrier reached full-scale negative");

endmodule

FILE: sv/srm_lane.sv
module srm_lane
    import srm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                           clk,
    input  lane_ctrl_t                     ctrl,
    input  logic signed [SAMPLE_BITS-1:0]  sample,
    input  logic signed [CARRIER_BITS-1:0] carrier,
    output logic signed [SAMPLE_BITS-1:0]  result
);

    localparam int PROD_BITS = SAMPLE_BITS + CARRIER_BITS;

    logic signed [SAMPLE_BITS-1:0] samp1_reg;
    logic signed [SAMPLE_BITS-1:0] samp2_reg;
    logic signed [PROD_BITS-1:0]   prod_next;
    logic signed [PROD_BITS-1:0]   prod2_reg;
    logic signed [SAMPLE_BITS:0]   scaled;
    logic signed [SAMPLE_BITS-1:0] sat;
    logic signed [SAMPLE_BITS-1:0] out_reg;
    logic signed [SAMPLE_BITS-1:0] out_next;

    assign prod_next = samp1_reg * carrier;

    // Sample capture, product and output registers
    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            samp1_reg <= sample;
            samp2_reg <= samp1_reg;
            prod2_reg <= prod_next;
            out_reg   <= out_next;
        end
    end

    // Floor by 2^15, saturate, or pass the sample in bypass
    always_comb
    begin
        scaled = prod2_reg[PROD_BITS-1:FRAC_BITS];
        if (scaled[SAMPLE_BITS] != scaled[SAMPLE_BITS-1])
        begin
            sat = scaled[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                      : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        else
        begin
            sat = scaled[SAMPLE_BITS-1:0];
        end
        out_next = ctrl.byp ? samp2_reg : sat;
    end

    assign result = out_reg;

endmodule

FILE: sv/stereo_ring_modulator.sv
// Each accepted item passes the lane sample, product and output registers.
// Throughput: one item per cycle unless stalled; the phase add and wrap are
// combinational, the carrier and two lane multiplies sit in stages behind it.
// When the output item is not taken, the whole pipeline stalls together.
// Reset clears the phase, the step register (bypass) and all valid flags.
module stereo_ring_modulator
    import srm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    srm_cfg_if.sink       cfg,
    srm_in_if.sink        samples,
    srm_out_if.source     modulated
);

    logic                           adv;
    logic                           accept;
    logic                           step_zero;
    logic signed [CARRIER_BITS-1:0] carrier;
    lane_ctrl_t                     lane_ctrl;
    logic                           v1_reg;
    logic                           v2_reg;
    logic                           v3_reg;
    logic                           byp1_reg;
    logic                           byp2_reg;
    logic                           last1_reg;
    logic                           last2_reg;
    logic                           last3_reg;
    logic signed [SAMPLE_BITS-1:0]  left_res;
    logic signed [SAMPLE_BITS-1:0]  right_res;

    // Pipeline moves whenever the output stage is empty or being taken
    assign adv           = !v3_reg || modulated.ready;
    assign accept        = samples.valid && adv;
    assign samples.ready = adv;
    assign cfg.ready     = 1'b1;

    assign lane_ctrl.adv = adv;
    assign lane_ctrl.byp = byp2_reg;

    srm_carrier u_carrier (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg.valid),
        .cfg_step  (cfg.phase_step),
        .adv       (adv),
        .accept    (accept),
        .step_zero (step_zero),
        .carrier   (carrier)
    );

    srm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
        .clk     (clk),
        .ctrl    (lane_ctrl),
        .sample  (samples.left_sample),
        .carrier (carrier),
        .result  (left_res)
    );

    srm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
        .clk     (clk),
        .ctrl    (lane_ctrl),
        .sample  (samples.right_sample),
        .carrier (carrier),
        .result  (right_res)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= samples.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Side fields riding along with the lanes
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            byp1_reg  <= step_zero;
            byp2_reg  <= byp1_reg;
            last1_reg <= samples.block_last;
            last2_reg <= last1_reg;
            last3_reg <= last2_reg;
        end
    end

    // Merge both lanes into the output item
    assign modulated.valid          = v3_reg;
    assign modulated.left_out       = left_res;
    assign modulated.right_out      = right_res;
    assign modulated.block_last_out = last3_reg;

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !modulated.ready) |=> (v3_reg && $stable(left_res)
                                          && $stable(right_res)))
        else $error("held output item changed");

    // Accepted item with ready held behind it at the output reaches the output stage
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept ##1 modulated.ready ##1 modulated.ready) |=> v3_reg)
        else $error("accepted item did not reach the output");

    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !modulated.ready) |-> !samples.ready)
        else $error("input taken while the pipeline is stalled");

endmodule

FILE: test/tb_stereo_ring_modulator.sv
`timescale 1ns / 1ps

module tb_stereo_ring_modulator;
    import srm_pkg::*;

    localparam int SB               = SAMPLE_BITS_DEF;
    localparam int CLK_PERIOD       = 10;
    localparam int STALL_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 10;
    localparam int MAX_REPORTS      = 10;
    localparam int RANDOM_PHASES    = 15;
    localparam int FRAMES_PER_PHASE = 100;
    localparam int NO_WRITE         = -1;

    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

    typedef struct packed {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
        logic                 last;
    } frame_t;

    // One row of the directed table
    typedef struct {
        int     step_wr;    // step written before the row, NO_WRITE for none
        frame_t stim;
        bit     known;      // result typed into the row
        frame_t want;
    } vector_t;

    typedef struct {
        bit     known;
        frame_t want;
    } preset_t;

    logic clk;
    logic rst_n;

    srm_cfg_if                     cfg_bus ();
    srm_in_if  #(.SAMPLE_BITS(SB)) frame_bus ();
    srm_out_if #(.SAMPLE_BITS(SB)) mod_bus ();

    stereo_ring_modulator #(.SAMPLE_BITS(SB)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_bus),
        .samples   (frame_bus),
        .modulated (mod_bus)
    );

    // Carrier model state
    logic [STEP_BITS-1:0]         step_reg;
    logic signed [PHASE_BITS-1:0] carrier_phase;

    preset_t preset_q[$];   // typed results, one per driven item
    frame_t  due_q[$];      // modulated frames still to come out
    vector_t vectors[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int errors;
    int idle_cycles;
    int frames_in;
    int frames_out;
    int step_writes;

    logic [STEP_BITS-1:0] corner_steps[6] = '{16'd1, 16'hFFFF, 16'd0, 16'h8000, 16'h7FFF, 16'd2};

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Parabolic sine: 4|p|(pi-|p|), clamped, signed like the phase
    function automatic logic signed [CARRIER_BITS-1:0] carrier_gain(
        logic signed [PHASE_BITS-1:0] p);
        longint mag;
        longint rest;
        longint m;
        mag  = (p < 0) ? -longint'(p) : longint'(p);
        rest = longint'(PHASE_PI) - mag;
        if (rest < 0)
            rest = 0;
        m = (4 * mag * rest) >>> FRAC_BITS;
        if (m > longint'(CARRIER_MAX))
            m = longint'(CARRIER_MAX);
        return CARRIER_BITS'((p < 0) ? -m : m);
    endfunction

    // Sample times carrier, floored and saturated
    function automatic logic signed [SB-1:0] scale_sample(logic signed [SB-1:0] s,
                                                          logic signed [CARRIER_BITS-1:0] c);
        longint prod;
        prod = (longint'(s) * longint'(c)) >>> FRAC_BITS;
        if (prod > longint'(S_MAX))
            prod = longint'(S_MAX);
        if (prod < longint'(S_MIN))
            prod = longint'(S_MIN);
        return prod[SB-1:0];
    endfunction

    // Next output frame; advances the phase unless bypassed
    function automatic frame_t modulate_frame(frame_t f);
        frame_t                         r;
        logic signed [CARRIER_BITS-1:0] c;
        logic signed [PHASE_BITS:0]     sum;
        r = f;
        if (step_reg != '0)
        begin
            c       = carrier_gain(carrier_phase);
            r.left  = scale_sample(f.left, c);
            r.right = scale_sample(f.right, c);
            sum     = carrier_phase + $signed({1'b0, step_reg});
            if (sum > PHASE_PI)
                sum = sum - PHASE_TWO_PI;
            carrier_phase = sum[PHASE_BITS-1:0];
        end
        return r;
    endfunction

    function automatic vector_t row(int step_wr, logic signed [SB-1:0] l,
                                    logic signed [SB-1:0] r, logic last, bit known,
                                    logic signed [SB-1:0] wl = '0,
                                    logic signed [SB-1:0] wr = '0);
        vector_t v;
        v.step_wr    = step_wr;
        v.stim.left  = l;
        v.stim.right = r;
        v.stim.last  = last;
        v.known      = known;
        v.want.left  = wl;
        v.want.right = wr;
        v.want.last  = last;
        return v;
    endfunction

    function automatic logic signed [SB-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return SB'($signed($urandom_range(0, 31)) - 16);
            default: return SB'($urandom());
        endcase
    endfunction

    task automatic set_idling(int mode);
        case (mode)
            0:       begin tx_idle_pct = 32; rx_idle_pct = 67; end
            1:       begin tx_idle_pct = 67; rx_idle_pct = 32; end
            default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        endcase
    endtask

    // Drive one frame, hold until taken; returns at a falling edge
    task automatic send_frame(frame_t f, bit known, frame_t want);
        preset_t p;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            frame_bus.valid <= 1'b0;
            @(negedge clk);
        end
        p.known = known;
        p.want  = want;
        preset_q.push_back(p);
        frame_bus.valid        <= 1'b1;
        frame_bus.left_sample  <= f.left;
        frame_bus.right_sample <= f.right;
        frame_bus.block_last   <= f.last;
        do @(posedge clk); while (!frame_bus.ready);
        @(negedge clk);
    endtask

    // Step write, only once every pending frame has come out
    task automatic write_step(logic [STEP_BITS-1:0] step);
        frame_bus.valid <= 1'b0;
        while (due_q.size() != 0)
            @(negedge clk);
        cfg_bus.valid      <= 1'b1;
        cfg_bus.phase_step <= step;
        do @(posedge clk); while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Output ready with random stalls
    initial
    begin
        mod_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            mod_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Predict on every accepted item, check every accepted result
    always @(posedge clk)
    begin : scoreboard
        preset_t p;
        frame_t  taken;
        frame_t  want;
        frame_t  got;
        bit      moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                step_reg = cfg_bus.phase_step;
                step_writes++;
                moved = 1'b1;
            end
            if (frame_bus.valid && frame_bus.ready)
            begin
                taken.left  = frame_bus.left_sample;
                taken.right = frame_bus.right_sample;
                taken.last  = frame_bus.block_last;
                want        = modulate_frame(taken);
                p           = preset_q.pop_front();
                due_q.push_back(p.known ? p.want : want);
                frames_in++;
                moved = 1'b1;
            end
            if (mod_bus.valid && mod_bus.ready)
            begin
                got.left  = mod_bus.left_out;
                got.right = mod_bus.right_out;
                got.last  = mod_bus.block_last_out;
                frames_out++;
                moved = 1'b1;
                if (due_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("[%0t] result with nothing pending: L=%0d R=%0d last=%0b",
                                 $time, got.left, got.right, got.last);
                end
                else
                begin
                    want = due_q.pop_front();
                    if (got.left !== want.left || got.right !== want.right ||
                        got.last !== want.last)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("[%0t] mismatch: exp L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                                     $time, want.left, want.right, want.last,
                                     got.left, got.right, got.last);
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on cycles with no handshake at all
    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("Stalled for %0d cycles with %0d frames pending", STALL_LIMIT, due_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        logic [STEP_BITS-1:0] step;
        frame_t               f;
        frame_t               none;

        rst_n                  = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.phase_step     = '0;
        frame_bus.valid        = 1'b0;
        frame_bus.left_sample  = '0;
        frame_bus.right_sample = '0;
        frame_bus.block_last   = 1'b0;
        step_reg               = '0;
        carrier_phase          = '0;
        errors                 = 0;
        idle_cycles            = 0;
        frames_in              = 0;
        frames_out             = 0;
        step_writes            = 0;
        none                   = '0;
        set_idling(0);

        // Directed table
        // bypass out of reset: samples pass unchanged
        vectors.push_back(row(NO_WRITE, S_MAX, S_MIN, 1, 1, S_MAX, S_MIN));
        vectors.push_back(row(NO_WRITE, S_MIN, S_MAX, 0, 1, S_MIN, S_MAX));
        vectors.push_back(row(NO_WRITE, 0, -1, 1, 1, 0, -1));
        vectors.push_back(row(NO_WRITE, 24'h555555, 24'hAAAAAA, 0, 1, 24'h555555, 24'hAAAAAA));
        // quarter-turn step: phase runs 0, pi/2, pi, -pi/2, 0
        vectors.push_back(row(16384, S_MAX, S_MIN, 0, 1, 0, 0));   // zero carrier
        vectors.push_back(row(NO_WRITE, S_MAX, S_MIN, 1, 0));      // full positive carrier
        vectors.push_back(row(NO_WRITE, 123456, -1, 0, 1, 0, 0));  // phase exactly pi
        vectors.push_back(row(NO_WRITE, S_MIN, S_MAX, 1, 0));      // full negative carrier
        vectors.push_back(row(NO_WRITE, -1, 1, 0, 1, 0, 0));       // back at zero
        // step above pi: wraps on every frame
        vectors.push_back(row(65535, S_MAX, S_MIN, 1, 0));
        vectors.push_back(row(NO_WRITE, S_MIN, S_MAX, 0, 0));
        vectors.push_back(row(NO_WRITE, -1, 1, 1, 0));
        // smallest step: tiny carriers, floor on negative products
        vectors.push_back(row(1, -1, 1, 0, 0));
        vectors.push_back(row(NO_WRITE, S_MIN, -7, 1, 0));
        vectors.push_back(row(NO_WRITE, S_MAX, 7, 0, 0));
        // bypass again: phase holds
        vectors.push_back(row(0, S_MAX, -2, 1, 1, S_MAX, -2));
        vectors.push_back(row(NO_WRITE, 24'hAAAAAA, 24'h555555, 0, 1, 24'hAAAAAA, 24'h555555));
        // half-turn step
        vectors.push_back(row(32768, S_MAX, S_MIN, 1, 0));
        vectors.push_back(row(NO_WRITE, S_MIN, S_MAX, 0, 0));
        vectors.push_back(row(NO_WRITE, 4567, -4567, 1, 0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (vectors[i])
        begin
            if (vectors[i].step_wr != NO_WRITE)
                write_step(STEP_BITS'(vectors[i].step_wr));
            send_frame(vectors[i].stim, vectors[i].known, vectors[i].want);
        end

        // Random frames over a series of step settings and idle patterns
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_idling(ph * 3 / RANDOM_PHASES);
            if (ph < 6)
                step = corner_steps[ph];
            else if ($urandom_range(0, 1) == 0)
                step = STEP_BITS'($urandom_range(1, 512));
            else
                step = STEP_BITS'($urandom());
            write_step(step);
            for (int n = 0; n < FRAMES_PER_PHASE; n++)
            begin
                f.left  = random_sample();
                f.right = random_sample();
                f.last  = 1'($urandom_range(0, 1));
                send_frame(f, 1'b0, none);
            end
        end

        // Drain
        frame_bus.valid <= 1'b0;
        while (due_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d stereo frames under %0d phase-step writes, bypass and wrap included;",
                 frames_in, step_writes);
        $display("checked %0d modulated frames, %0d errors", frames_out, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
sv/srm_pkg.sv
sv/srm_in_if.sv
sv/srm_out_if.sv
sv/srm_cfg_if.sv
sv/srm_carrier.sv
sv/srm_lane.sv
sv/stereo_ring_modulator.sv
test/tb_stereo_ring_modulator.sv
